FILE: design/glp_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and register codes for the grid longest-path block.
// Used by the channel interfaces, the row buffer, the top level and the checker.
package glp_pkg;

  // Field widths.
  localparam int WEIGHT_W   = 16;
  localparam int VAL_W      = 26;
  localparam int LEN_W      = 25;
  localparam int EDGE_W     = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  // Default depth of the row buffer.
  localparam int MAX_NODES_PER_ROW_DEF = 256;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_EDGES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_EDGES = 1'd1;

  typedef logic [WEIGHT_W-1:0] weight_t;
  typedef logic [VAL_W-1:0]    val_t;
  typedef logic [LEN_W-1:0]    len_t;
  typedef logic [EDGE_W-1:0]   edge_t;

  // Access strobes from the node pipeline to the row buffer.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } buf_ctrl_t;

endpackage

FILE: design/glp_node_if.sv
`timescale 1ns / 1ps
// Input channel: one grid node per transaction with its two entering edge weights.
// Depends on glp_pkg for the weight type.
interface glp_node_if;
  logic            valid;
  logic            ready;
  glp_pkg::weight_t weight_from_above;
  glp_pkg::weight_t weight_from_left;

  modport source(output valid, output weight_from_above, output weight_from_left,
                 input ready);
  modport sink(input valid, input weight_from_above, input weight_from_left,
               output ready);
endinterface

FILE: design/glp_result_if.sv
`timescale 1ns / 1ps
// Output channel: one path length per transaction, sent at the last node of a grid.
// Depends on glp_pkg for the length type.
interface glp_result_if;
  logic          valid;
  logic          ready;
  glp_pkg::len_t path_length;

  modport source(output valid, output path_length, input ready);
  modport sink(input valid, input path_length, output ready);
endinterface

FILE: design/glp_row_buf.sv
`timescale 1ns / 1ps
// Row buffer: synchronous memory of node values with a registered read port.
// Forwards a write that lands on the slot being read in the same cycle. Uses glp_pkg.
module glp_row_buf #(
  parameter int DEPTH  = glp_pkg::MAX_NODES_PER_ROW_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic               clk,
  input  glp_pkg::buf_ctrl_t ctrl,
  input  logic [ADDR_W-1:0]  rd_addr,
  input  logic [ADDR_W-1:0]  wr_addr,
  input  glp_pkg::val_t      wr_data,
  output glp_pkg::val_t      rd_data
);

  glp_pkg::val_t mem [DEPTH];
  glp_pkg::val_t rd_q;
  glp_pkg::val_t fwd_q;
  logic          fwd_hit;

  // Write port.
  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; the data and the bypass choice hold until the next read.
  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      rd_q    <= mem[rd_addr];
      fwd_q   <= wr_data;
      fwd_hit <= ctrl.wr_en && (wr_addr == rd_addr);
    end
  end

  // A read that collided with a write returns the new value.
  assign rd_data = fwd_hit ? fwd_q : rd_q;

endmodule

FILE: design/grid_longest_path.sv
`timescale 1ns / 1ps
// Grid longest-path engine (Manhattan tourist). Depends on glp_pkg, glp_node_if,
// glp_result_if and glp_row_buf.
//
// Usage: write row_edges (index 0) and col_edges (index 1) on the cfg port while
// the block is idle. Then stream the (row_edges+1) x (col_edges+1) grid nodes in
// row-major order on the node channel, one node per transaction, each carrying
// the weight of the edge from above and the edge from the left. After the last
// node of the grid the block sends one transaction on the result channel with
// the longest path length, and the position returns to the top-left node.
//
// Throughput is one node per cycle unless the result stalls. Each node passes two
// stages: the first issues the read of the previous row's value from the row
// buffer memory, the second adds the weights, takes the maximum and writes the
// value back; the result then goes to the output register. A write that hits the
// slot being read in the same cycle is forwarded inside the row buffer.
//
// Reset clears the position, the left value, the registers and the output
// register; the row buffer is not cleared, since every slot is written in the
// first row before a read of it is used. When the receiver stalls, the result
// waits in the output register and nodes keep flowing until the next final node
// reaches the second stage, which then holds and drops node ready.
module grid_longest_path #(
  parameter int MAX_NODES_PER_ROW = glp_pkg::MAX_NODES_PER_ROW_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [glp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [glp_pkg::CFG_DATA_W-1:0]   cfg_data,
  glp_node_if.sink                         node,
  glp_result_if.source                     result
);

  localparam int SLOT_W = $clog2(MAX_NODES_PER_ROW);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(MAX_NODES_PER_ROW - 1);

  // Configuration registers.
  glp_pkg::edge_t row_edges;
  glp_pkg::edge_t col_edges;

  // Position of the next node.
  glp_pkg::edge_t    row_index;
  glp_pkg::edge_t    col_index;
  logic [SLOT_W-1:0] slot;

  // Second stage.
  logic              s1_valid;
  glp_pkg::weight_t  s1_wa;
  glp_pkg::weight_t  s1_wl;
  logic              s1_row_nz;
  logic              s1_col_nz;
  logic              s1_final;
  logic [SLOT_W-1:0] s1_slot;

  glp_pkg::val_t      left_value;
  glp_pkg::val_t      above_value;
  glp_pkg::val_t      from_above;
  glp_pkg::val_t      from_left;
  glp_pkg::val_t      val;
  glp_pkg::buf_ctrl_t buf_ctrl;

  logic accept;
  logic advance;
  logic last_col;
  logic final_node;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_edges <= '0;
      col_edges <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        glp_pkg::CFG_ROW_EDGES: row_edges <= cfg_data;
        glp_pkg::CFG_COL_EDGES: col_edges <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake: the second stage moves on unless a final node meets a full output.
  assign advance    = s1_valid && !(s1_final && result.valid && !result.ready);
  assign node.ready = !s1_valid || advance;
  assign accept     = node.valid && node.ready;

  // Position tracking in the first stage.
  assign last_col   = col_index >= col_edges;
  assign final_node = last_col && (row_index >= row_edges);

  always_ff @(posedge clk) begin
    if (rst) begin
      row_index <= '0;
      col_index <= '0;
      slot      <= '0;
    end else if (accept) begin
      if (final_node) begin
        row_index <= '0;
        col_index <= '0;
        slot      <= '0;
      end else if (last_col) begin
        row_index <= row_index + 1'b1;
        col_index <= '0;
        slot      <= '0;
      end else begin
        col_index <= col_index + 1'b1;
        slot      <= (slot == SLOT_LAST) ? '0 : slot + 1'b1;
      end
    end
  end

  // First-to-second stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (node.ready) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_wa     <= node.weight_from_above;
      s1_wl     <= node.weight_from_left;
      s1_row_nz <= row_index != '0;
      s1_col_nz <= col_index != '0;
      s1_final  <= final_node;
      s1_slot   <= slot;
    end
  end

  // Row buffer: read at accept, write back when the second stage completes.
  assign buf_ctrl.rd_en = accept;
  assign buf_ctrl.wr_en = advance;

  glp_row_buf #(
    .DEPTH  (MAX_NODES_PER_ROW),
    .ADDR_W (SLOT_W)
  ) u_row_buf (
    .clk     (clk),
    .ctrl    (buf_ctrl),
    .rd_addr (slot),
    .wr_addr (s1_slot),
    .wr_data (val),
    .rd_data (above_value)
  );

  // Node value: maximum over the predecessors inside the grid.
  assign from_above = above_value + glp_pkg::VAL_W'(s1_wa);
  assign from_left  = left_value + glp_pkg::VAL_W'(s1_wl);

  always_comb begin
    val = '0;
    if (s1_row_nz && s1_col_nz) begin
      val = (from_above > from_left) ? from_above : from_left;
    end else if (s1_row_nz) begin
      val = from_above;
    end else if (s1_col_nz) begin
      val = from_left;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_value <= '0;
    end else if (advance) begin
      left_value <= val;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (advance && s1_final) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_final) begin
      result.path_length <= val[glp_pkg::LEN_W-1:0];
    end
  end

endmodule

FILE: design/glp_checker.sv
`timescale 1ns / 1ps
// Port-level checker for grid_longest_path, attached by the bind below.
// Depends on glp_pkg for the output width.
module glp_checker (
  input logic          clk,
  input logic          rst,
  input logic          node_valid,
  input logic          node_ready,
  input logic          result_valid,
  input logic          result_ready,
  input glp_pkg::len_t path_length
);

  // A pending result transaction is held until it is taken.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("result valid dropped while stalled");

  // The path length is stable while the result is stalled.
  a_result_stable: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> $stable(path_length))
    else $error("path length changed while stalled");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

  // A new result follows its node through the second-stage and output registers.
  a_result_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(node_valid && node_ready, 2))
    else $error("result without a node two cycles before");

endmodule

bind grid_longest_path glp_checker u_glp_checker (
  .clk          (clk),
  .rst          (rst),
  .node_valid   (node.valid),
  .node_ready   (node.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .path_length  (result.path_length)
);
